[rtl/fsqp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqp_pkg: shared types and constants of the filterbank quantiser and packer
// Widths of the sample, code, packed word and running sums, the register
// indexes of the configuration port and the record that moves along the
// row of divider cells.
// ----------------------------------------------------------------------------
package fsqp_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned CODE_W      = 16;   // widest code: 2^4 bits
  localparam int unsigned CELL_COUNT  = CODE_W;
  localparam int unsigned LG_W        = 3;
  localparam int unsigned LG_MAX      = 4;
  localparam int unsigned NBITS_W     = 5;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned DEV_W       = CODE_W + 1;
  localparam int unsigned SQ_W        = 2 * DEV_W;
  localparam int unsigned CODE_SUM_W  = 48;
  localparam int unsigned DEV_SUM_W   = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LOW  = 2'd0,
    CFG_CLIP_HIGH = 2'd1,
    CFG_BITS_LOG2 = 2'd2
  } cfg_idx_e;

  // One item on its way through the divider row
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic                    full;   // sample at or above the upper clip
    logic                    empty;  // range empty or inverted
    logic [SAMPLE_BITS-1:0]  rem;
    logic [CODE_W-1:0]       quo;
  } cell_t;

endpackage

[rtl/fsqp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqp_in_if / fsqp_out_if: valid/ready channels of the quantiser
// A transfer happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface fsqp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_channel;

  modport source (output valid, output sample, output last_channel, input ready);
  modport sink   (input valid, input sample, input last_channel, output ready);
endinterface

interface fsqp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  logic        spectrum_end;
  logic [47:0] code_sum;
  logic [63:0] deviation_sq_sum;

  modport source (output valid, output packed_word, output spectrum_end,
                  output code_sum, output deviation_sq_sum, input ready);
  modport sink   (input valid, input packed_word, input spectrum_end,
                  input code_sum, input deviation_sq_sum, output ready);
endinterface

[rtl/fsqp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqp_cell: one restoring division step
// Doubles the partial remainder, subtracts the clip range where it fits and
// shifts one quotient bit in. An inactive cell hands its item on unchanged.
// ----------------------------------------------------------------------------
module fsqp_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 active_i,
  input  logic [fsqp_pkg::SAMPLE_BITS-1:0]     range_i,
  input  fsqp_pkg::cell_t                      up_i,
  output fsqp_pkg::cell_t                      dn_o
);
  import fsqp_pkg::*;

  logic [SAMPLE_BITS:0]   rem2;
  logic [SAMPLE_BITS:0]   diff;
  logic                   fits;
  cell_t                  nxt;
  cell_t                  cur_q;

  // Trial subtraction
  always_comb begin
    rem2 = {up_i.rem, 1'b0};
    diff = rem2 - {1'b0, range_i};
    fits = (rem2 >= {1'b0, range_i});
    nxt  = up_i;
    if (active_i) begin
      nxt.rem = fits ? diff[SAMPLE_BITS-1:0] : rem2[SAMPLE_BITS-1:0];
      nxt.quo = {up_i.quo[CODE_W-2:0], fits};
    end
  end

  // Advance the item, clear it on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (adv_i) begin
      cur_q <= nxt;
    end
  end

  assign dn_o = cur_q;

endmodule

[rtl/fsqp_pack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqp_pack: code fix-up, squared deviation and word packing
// Saturates the quotient into a code, squares its distance from mid-scale,
// ORs the code into the partial word, keeps both running sums and holds the
// finished word in the output register.
// ----------------------------------------------------------------------------
module fsqp_pack (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [fsqp_pkg::LG_W-1:0]      lg_i,
  input  fsqp_pkg::cell_t                tail_i,
  output logic                           adv_o,
  fsqp_out_if.source                     out_o
);
  import fsqp_pkg::*;

  logic [NBITS_W-1:0]      nbits;
  logic [CODE_W-1:0]       mask;
  logic [CODE_W-1:0]       code_d;
  logic [DEV_W-1:0]        twice;
  logic [DEV_W-1:0]        mid;
  logic [DEV_W-1:0]        dev_d;

  logic                    c_valid_q;
  logic                    c_last_q;
  logic [CODE_W-1:0]       c_code_q;
  logic [DEV_W-1:0]        c_dev_q;

  logic                    m_valid_q;
  logic                    m_last_q;
  logic [CODE_W-1:0]       m_code_q;
  logic [SQ_W-1:0]         m_sq_q;

  logic [WORD_BITS-1:0]    word_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [CODE_SUM_W-1:0]   ctot_q;
  logic [DEV_SUM_W-1:0]    dtot_q;

  logic                    ovalid_q;
  logic [WORD_BITS-1:0]    oword_q;
  logic                    oend_q;
  logic [CODE_SUM_W-1:0]   osum_q;
  logic [DEV_SUM_W-1:0]    odev_q;

  logic [8:0]              pos;
  logic [SLOT_W:0]         slot_inc;
  logic [9:0]              fill;
  logic                    emit;
  logic [WORD_BITS-1:0]    word_d;
  logic [CODE_SUM_W:0]     csum;
  logic [DEV_SUM_W:0]      dsum;
  logic [CODE_SUM_W-1:0]   ctot_d;
  logic [DEV_SUM_W-1:0]    dtot_d;

  // Whole row moves unless a finished word is still waiting
  assign adv_o = !ovalid_q || out_o.ready;

  // Code fix-up and distance from mid-scale
  always_comb begin
    nbits = NBITS_W'(1) << lg_i;
    mask  = {CODE_W{1'b1}} >> (NBITS_W'(CODE_W) - nbits);
    if (tail_i.empty) begin
      code_d = '0;
    end else if (tail_i.full) begin
      code_d = mask;
    end else begin
      code_d = tail_i.quo & mask;
    end
    twice = {code_d, 1'b0};
    mid   = {1'b0, mask};
    dev_d = (twice >= mid) ? (twice - mid) : (mid - twice);
  end

  // Packing and saturating sums
  always_comb begin
    pos      = 9'(slot_q) << lg_i;
    slot_inc = (SLOT_W+1)'(slot_q) + (SLOT_W+1)'(1);
    fill     = 10'(slot_inc) << lg_i;
    emit     = m_last_q || (fill >= 10'(WORD_BITS));
    word_d   = word_q;
    if (pos < 9'(WORD_BITS)) begin
      word_d = word_q | (WORD_BITS'(m_code_q) << pos[4:0]);
    end
    csum   = {1'b0, ctot_q} + (CODE_SUM_W+1)'(m_code_q);
    dsum   = {1'b0, dtot_q} + (DEV_SUM_W+1)'(m_sq_q);
    ctot_d = csum[CODE_SUM_W] ? {CODE_SUM_W{1'b1}} : csum[CODE_SUM_W-1:0];
    dtot_d = dsum[DEV_SUM_W] ? {DEV_SUM_W{1'b1}} : dsum[DEV_SUM_W-1:0];
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (adv_o) begin
      c_valid_q <= tail_i.valid;
      m_valid_q <= c_valid_q;
    end
  end

  // Stage payloads: code, then square
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      c_last_q <= tail_i.last;
      c_code_q <= code_d;
      c_dev_q  <= dev_d;
      m_last_q <= c_last_q;
      m_code_q <= c_code_q;
      m_sq_q   <= SQ_W'(c_dev_q) * SQ_W'(c_dev_q);
    end
  end

  // Partial word, slot count and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q   <= '0;
      slot_q   <= '0;
      ctot_q   <= '0;
      dtot_q   <= '0;
      ovalid_q <= 1'b0;
    end else if (adv_o) begin
      ovalid_q <= m_valid_q && emit;
      if (m_valid_q) begin
        ctot_q <= ctot_d;
        dtot_q <= dtot_d;
        if (emit) begin
          word_q <= '0;
          slot_q <= '0;
        end else begin
          word_q <= word_d;
          slot_q <= slot_inc[SLOT_W-1:0];
        end
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (adv_o && m_valid_q && emit) begin
      oword_q <= word_d;
      oend_q  <= m_last_q;
      osum_q  <= ctot_d;
      odev_q  <= dtot_d;
    end
  end

  assign out_o.valid            = ovalid_q;
  assign out_o.packed_word      = oword_q;
  assign out_o.spectrum_end     = oend_q;
  assign out_o.code_sum         = osum_q;
  assign out_o.deviation_sq_sum = odev_q;

  // A closed word restarts at slot zero
  a_slot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o && m_valid_q && emit |=> slot_q == '0)
    else $error("slot count not cleared after word");

  // Running sums never fall
  a_sum_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctot_q >= $past(ctot_q)) && (dtot_q >= $past(dtot_q)))
    else $error("running sum decreased");

  // Codes stay within the configured width
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> (c_code_q & ~mask) == '0)
    else $error("code exceeds bit width");

  // A word only appears from an item in the packing stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(m_valid_q))
    else $error("word without an item");

endmodule

[rtl/filterbank_sample_quantise_pack_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filterbank_sample_quantise_pack_core: n-bit quantiser and word packer
// Clips each channel sample, quantises it by restoring division through a
// row of sixteen cells and packs the codes into 32-bit words.
// ----------------------------------------------------------------------------
// The block takes one sample transfer per cycle while the output is not
// stalled and hands each word out through one input stage, sixteen
// division cells (one quotient bit each, unused cells pass the item on),
// a code stage, a squaring stage and the packing stage that loads the
// output register. While a finished word waits for its transfer the whole
// row holds, so input ready follows output ready. Configuration writes
// take effect at once and belong to times when no samples are in flight.
module filterbank_sample_quantise_pack_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fsqp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fsqp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  fsqp_in_if.sink                             in_i,
  fsqp_out_if.source                          out_o
);
  import fsqp_pkg::*;

  logic signed [SAMPLE_BITS-1:0] clip_low_q;
  logic signed [SAMPLE_BITS-1:0] clip_high_q;
  logic [LG_W-1:0]               bits_log2_q;

  logic [LG_W-1:0]               lg;
  logic [NBITS_W-1:0]            nbits;
  logic signed [SAMPLE_BITS:0]   range_w;
  logic                          empty;
  logic signed [SAMPLE_BITS-1:0] xc;
  logic signed [SAMPLE_BITS:0]   diff_w;
  logic                          adv;
  cell_t                         s_d;
  cell_t                         s_q;
  cell_t                         chain [CELL_COUNT+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_low_q  <= -16'sd1792;
      clip_high_q <= 16'sd1792;
      bits_log2_q <= LG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLIP_LOW:  clip_low_q  <= cfg_wdata_i;
        CFG_CLIP_HIGH: clip_high_q <= cfg_wdata_i;
        CFG_BITS_LOG2: bits_log2_q <= cfg_wdata_i[LG_W-1:0];
        default: ;
      endcase
    end
  end

  // Bit width and clip range
  always_comb begin
    lg      = (bits_log2_q > LG_W'(LG_MAX)) ? LG_W'(LG_MAX) : bits_log2_q;
    nbits   = NBITS_W'(1) << lg;
    range_w = {clip_high_q[SAMPLE_BITS-1], clip_high_q}
            - {clip_low_q[SAMPLE_BITS-1], clip_low_q};
    empty   = (clip_high_q <= clip_low_q);
  end

  // Clip the sample and take its offset from the lower level
  always_comb begin
    if (in_i.sample < clip_low_q) begin
      xc = clip_low_q;
    end else if (in_i.sample > clip_high_q) begin
      xc = clip_high_q;
    end else begin
      xc = in_i.sample;
    end
    diff_w = {xc[SAMPLE_BITS-1], xc} - {clip_low_q[SAMPLE_BITS-1], clip_low_q};
  end

  assign in_i.ready = adv;

  // Build the item for the input stage
  always_comb begin
    s_d.valid = in_i.valid;
    s_d.last  = in_i.last_channel;
    s_d.full  = (in_i.sample >= clip_high_q);
    s_d.empty = empty;
    s_d.rem   = diff_w[SAMPLE_BITS-1:0];
    s_d.quo   = '0;
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (adv) begin
      s_q <= s_d;
    end
  end

  assign chain[0] = s_q;

  // Row of division cells
  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    logic act;
    assign act = (NBITS_W'(k) < nbits);
    fsqp_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .active_i (act),
      .range_i  (range_w[SAMPLE_BITS-1:0]),
      .up_i     (chain[k]),
      .dn_o     (chain[k+1])
    );
  end

  // Code, square and pack
  fsqp_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lg_i   (lg),
    .tail_i (chain[CELL_COUNT]),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule

[tb/filterbank_sample_quantise_pack_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filterbank_sample_quantise_pack_core_test: self-checking bench of the packer
// Walks a table of directed samples and register writes, then runs random
// phases under different idle and stall patterns, one of them with a long
// hold-off on the output. Every packed word is compared field by field with
// a behavioural model of the clip, quantise, pack and sum path, or a typed row.
// ----------------------------------------------------------------------------
module filterbank_sample_quantise_pack_core_test;
  import fsqp_pkg::*;

  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned PHASE_COUNT     = 6;
  localparam int unsigned PHASE_ITEMS     = 200;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam logic [CODE_SUM_W-1:0] CODE_SUM_MAX = '1;

  typedef struct packed {
    logic [WORD_BITS-1:0]  word;
    logic                  fin;
    logic [CODE_SUM_W-1:0] code_sum;
    logic [DEV_SUM_W-1:0]  dev_sum;
  } word_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    cfg_idx_e     reg_idx;
    logic [15:0]  value;    // sample, or register data
    logic         last;
    logic         typed;    // expected word written out below
    word_result_t want;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 37;

  // Directed stimulus: extremes after reset, bit selector edges, empty and
  // inverted ranges, full-scale samples and width changes inside a word
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h8000, 1'b1, 1'b1, '{32'h0, 1'b1, 48'd0, 64'd9}},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h7FFF, 1'b1, 1'b1, '{32'h3, 1'b1, 48'd3, 64'd18}},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h0700, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'hF8FF, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h06FF, 1'b1, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h7FFF, 1'b1, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0007, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h7FFF, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h8000, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_CLIP_LOW,  16'h7FFF, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_CLIP_HIGH, 16'h8000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h3039, 1'b1, 1'b0, '0},
    '{ROW_REG,    CFG_CLIP_LOW,  16'h0064, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_CLIP_HIGH, 16'h0064, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h0064, 1'b1, 1'b0, '0},
    '{ROW_REG,    CFG_CLIP_LOW,  16'h8000, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_CLIP_HIGH, 16'h7FFF, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0004, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h7FFF, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h8000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h0000, 1'b1, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h7FFF, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0004, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h7FFF, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0003, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h1234, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'hEDCB, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h5555, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0004, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'hAAAA, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0005, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h7FFF, 1'b0, 1'b0, '0},
    '{ROW_REG,    CFG_BITS_LOG2, 16'h0006, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, CFG_CLIP_LOW,  16'h0001, 1'b1, 1'b0, '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fsqp_in_if  in_ch ();
  fsqp_out_if out_ch ();

  filterbank_sample_quantise_pack_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Register copies and packing state of the model
  logic signed [15:0]    shadow_lo;
  logic signed [15:0]    shadow_hi;
  logic [2:0]            shadow_lg;
  logic [WORD_BITS-1:0]  acc_word;
  int unsigned           acc_slots;
  logic [CODE_SUM_W-1:0] code_total;
  logic [DEV_SUM_W-1:0]  dev_total;

  word_result_t expected_words [$];
  int          mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  always #6 clk_i = ~clk_i;

  // Clip and quantise one sample; an empty or inverted range gives code 0
  function automatic longint unsigned quantise_code(logic [15:0] s, int unsigned nbits);
    longint lo;
    longint hi;
    longint x;
    longint q;
    lo = shadow_lo;
    hi = shadow_hi;
    x  = $signed(s);
    if (hi <= lo) return 0;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    q = ((x - lo) << nbits) / (hi - lo);
    // full scale saturates to the top code
    if (q >= (longint'(1) << nbits)) q = (longint'(1) << nbits) - 1;
    return q;
  endfunction

  // Advance the model by one sample; report the word if it closes one
  task automatic account_sample(input logic [15:0] s, input logic l,
                                output bit emitted, output word_result_t res);
    int unsigned       lg;
    int unsigned       nbits;
    int unsigned       pos;
    longint unsigned   code;
    longint unsigned   headroom;
    longint unsigned   mid;
    longint unsigned   twice;
    longint unsigned   dev;
    longint unsigned   sq;
    lg    = (shadow_lg > 3'd4) ? 4 : shadow_lg;
    nbits = 1 << lg;
    code  = quantise_code(s, nbits);
    // drop codes whose slot lies beyond the word
    pos = acc_slots * nbits;
    if (pos < WORD_BITS) acc_word = acc_word | 32'(code << pos);
    acc_slots++;
    headroom = CODE_SUM_MAX - code_total;
    if (headroom < code) code_total = CODE_SUM_MAX;
    else code_total = code_total + code;
    mid   = (64'd1 << nbits) - 1;
    twice = code << 1;
    dev   = (twice >= mid) ? (twice - mid) : (mid - twice);
    sq    = dev * dev;
    if (~64'd0 - dev_total < sq) dev_total = '1;
    else dev_total = dev_total + sq;
    emitted = l || (acc_slots * nbits >= WORD_BITS);
    res = '{acc_word, l, code_total, dev_total};
    if (emitted) begin
      acc_word  = '0;
      acc_slots = 0;
    end
  endtask

  // Offer one sample after a random gap and hold it until the transfer
  task automatic push_sample(input logic [15:0] s, input logic l, input logic typed,
                             input word_result_t want);
    bit           emitted;
    word_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= s;
    in_ch.last_channel <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    account_sample(s, l, emitted, res);
    if (emitted) expected_words = {expected_words, (typed ? want : res)};
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every word, then let samples without a word drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_CLIP_LOW:  shadow_lo = data;
      CFG_CLIP_HIGH: shadow_hi = data;
      CFG_BITS_LOG2: shadow_lg = data[2:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Pick a clip range (mostly ordered, sometimes narrow, now and then raw)
  // and a bit selector over its whole field
  task automatic randomise_setting();
    int lo_i;
    int hi_i;
    int swap;
    int unsigned pick;
    pick = $urandom_range(0, 7);
    lo_i = int'($urandom_range(0, 65535)) - 32768;
    hi_i = int'($urandom_range(0, 65535)) - 32768;
    if (pick >= 1 && pick <= 2) begin
      lo_i = int'($urandom_range(0, 65535 - 64)) - 32768;
      hi_i = lo_i + int'($urandom_range(1, 64));
    end else if (pick > 2) begin
      if (lo_i > hi_i) begin
        swap = lo_i;
        lo_i = hi_i;
        hi_i = swap;
      end
      if (lo_i == hi_i) begin
        if (hi_i < 32767) hi_i++;
        else lo_i--;
      end
    end
    write_reg(CFG_CLIP_LOW, 16'(lo_i));
    write_reg(CFG_CLIP_HIGH, 16'(hi_i));
    write_reg(CFG_BITS_LOG2, 16'($urandom_range(0, 7)));
  endtask

  // Mostly samples within the clip range, the rest anywhere in the field
  function automatic logic [15:0] random_sample();
    int lo_i;
    int hi_i;
    lo_i = shadow_lo;
    hi_i = shadow_hi;
    if (hi_i > lo_i && $urandom_range(0, 3) != 0)
      return 16'(lo_i + int'($urandom_range(0, hi_i - lo_i)));
    return 16'($urandom);
  endfunction

  // Output ready: long hold-off when asked, else random stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each word transfer with the oldest expectation
  always @(posedge clk_i) begin
    word_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: packed_word %h", out_ch.packed_word);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_ch.packed_word !== want.word) begin
          $error("packed_word: expected %h, got %h", want.word, out_ch.packed_word);
          mismatch_count++;
        end
        if (out_ch.spectrum_end !== want.fin) begin
          $error("spectrum_end: expected %b, got %b", want.fin, out_ch.spectrum_end);
          mismatch_count++;
        end
        if (out_ch.code_sum !== want.code_sum) begin
          $error("code_sum: expected %0d, got %0d", want.code_sum, out_ch.code_sum);
          mismatch_count++;
        end
        if (out_ch.deviation_sq_sum !== want.dev_sum) begin
          $error("deviation_sq_sum: expected %0d, got %0d", want.dev_sum,
                 out_ch.deviation_sq_sum);
          mismatch_count++;
        end
      end
    end
  end

  // Stop the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit settled;
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_CLIP_LOW;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.last_channel = 1'b0;
    out_ch.ready       = 1'b0;
    shadow_lo          = -16'sd1792;
    shadow_hi          = 16'sd1792;
    shadow_lg          = 3'd1;
    acc_word           = '0;
    acc_slots          = 0;
    code_total         = '0;
    dev_total          = '0;
    mismatch_count     = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_left          = 0;
    quiet_cycles       = 0;
    settled            = 1'b1;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; registers change only once the pipeline is empty
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        if (!settled) settle();
        settled = 1'b1;
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
      end else begin
        push_sample(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].typed,
                    DIRECTED[i].want);
        settled = 1'b0;
      end
    end

    // Random phases; partial words carry over into the next setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      // hold the output back so the row fills and stalls its input
      if (p == 4) hold_left = HOLD_OFF_CYCLES;
      randomise_setting();
      repeat (PHASE_ITEMS) push_sample(random_sample(), $urandom_range(0, 5) == 0, 1'b0, '0);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
